>>> hdl/gsps_pkg.sv
// Package for the ground seed point search unit: sizes, codes and payload types.
`default_nettype none

package gsps_pkg;

    localparam int COORD_W    = 24;
    localparam int INT_W      = 32;
    localparam int R_W        = 23;
    localparam int SEED_CFG_W = 4;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_POINTS = 4096;
    localparam int PT_IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PT_CNT_W   = $clog2(MAX_POINTS + 1);

    localparam int MAX_SEEDS  = 8;
    localparam int SEED_W     = $clog2(MAX_SEEDS + 1);

    // result queue holds one full query on top of what may still wait
    localparam int FIFO_DEPTH = 2 * MAX_SEEDS;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W - 1;
    localparam int SUM_W  = SQ_W + 1;
    localparam int R2_W   = 2 * R_W;
    localparam int Z_W    = COORD_W + 2;

    localparam int XY_W = 2 * COORD_W;
    localparam int ZI_W = COORD_W + INT_W;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_RADIUS = 2'd0,
        CFG_HEIGHT_OFFSET = 2'd1,
        CFG_HEIGHT_MARGIN = 2'd2,
        CFG_MAX_SEEDS     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [INT_W-1:0]          intensity;
    } req_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] seed_x;
        logic signed [COORD_W-1:0] seed_y;
        logic signed [COORD_W-1:0] seed_z;
        logic [INT_W-1:0]          seed_intensity;
        logic                      seed_valid;
        logic                      last;
    } rsp_item_t;

    // tag travelling with each point read through the compare pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } scan_tag_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } match_tag_t;

    // pose values latched when a query transaction is taken
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [Z_W-1:0]     zlo;
        logic signed [Z_W-1:0]     zhi;
        logic [R2_W-1:0]           r2;
    } query_t;

endpackage

`default_nettype wire

>>> hdl/gsps_point_store.sv
// Point store: x/y memory and z/intensity memory, one write and one registered read port.
`default_nettype none

module gsps_point_store
(
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [gsps_pkg::PT_IDX_W-1:0] wr_addr,
    input  wire logic [gsps_pkg::XY_W-1:0]     wr_xy,
    input  wire logic [gsps_pkg::ZI_W-1:0]     wr_zi,
    input  wire logic                          rd_en,
    input  wire logic [gsps_pkg::PT_IDX_W-1:0] rd_addr,
    output logic      [gsps_pkg::XY_W-1:0]     rd_xy,
    output logic      [gsps_pkg::ZI_W-1:0]     rd_zi
);
    import gsps_pkg::*;

    logic [XY_W-1:0] xy_mem [MAX_POINTS];
    logic [ZI_W-1:0] zi_mem [MAX_POINTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            xy_mem[wr_addr] <= wr_xy;
            zi_mem[wr_addr] <= wr_zi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_xy <= xy_mem[rd_addr];
            rd_zi <= zi_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/gsps_match_pipe.sv
// Three-stage radius and height window test on points read from the store.
`default_nettype none

module gsps_match_pipe
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      flush,
    input  wire gsps_pkg::query_t          query,
    input  wire gsps_pkg::scan_tag_t       in_tag,
    input  wire logic [gsps_pkg::XY_W-1:0] in_xy,
    input  wire logic [gsps_pkg::ZI_W-1:0] in_zi,
    output gsps_pkg::match_tag_t           out_tag,
    output gsps_pkg::rsp_item_t            out_point
);
    import gsps_pkg::*;

    logic signed [COORD_W-1:0] x_in, y_in, z_in;
    logic signed [Z_W-1:0]     z_ext;
    logic signed [DIFF_W-1:0]  dx_next, dy_next;
    logic                      zok_next;

    scan_tag_t                 s2_tag_reg, s3_tag_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic                      s2_zok_reg, s3_zok_reg;
    rsp_item_t                 s2_pt_reg, s3_pt_reg;

    logic signed [2*DIFF_W-1:0] prod_x, prod_y;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg;
    logic [SUM_W-1:0]           d2;
    logic                       hit_next;

    match_tag_t                 s4_tag_reg;
    rsp_item_t                  s4_pt_reg;

    // stage 2: differences and z window
    always_comb
    begin
        x_in     = in_xy[COORD_W-1:0];
        y_in     = in_xy[XY_W-1:COORD_W];
        z_in     = in_zi[COORD_W-1:0];
        z_ext    = {{(Z_W-COORD_W){z_in[COORD_W-1]}}, z_in};
        dx_next  = {x_in[COORD_W-1], x_in} - {query.px[COORD_W-1], query.px};
        dy_next  = {y_in[COORD_W-1], y_in} - {query.py[COORD_W-1], query.py};
        zok_next = (z_ext >= query.zlo) && (z_ext <= query.zhi);
    end

    // stage 3: squares
    always_comb
    begin
        prod_x = dx_reg * dx_reg;
        prod_y = dy_reg * dy_reg;
    end

    // stage 4: sum and radius compare
    always_comb
    begin
        d2       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        hit_next = s3_zok_reg && (d2 <= {{(SUM_W-R2_W){1'b0}}, query.r2});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
        end
        else if (flush)
        begin
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
        end
        else
        begin
            s2_tag_reg       <= in_tag;
            s3_tag_reg       <= s2_tag_reg;
            s4_tag_reg.valid <= s3_tag_reg.valid;
            s4_tag_reg.last  <= s3_tag_reg.last;
            s4_tag_reg.hit   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg                   <= dx_next;
        dy_reg                   <= dy_next;
        s2_zok_reg               <= zok_next;
        s2_pt_reg.seed_x         <= x_in;
        s2_pt_reg.seed_y         <= y_in;
        s2_pt_reg.seed_z         <= z_in;
        s2_pt_reg.seed_intensity <= in_zi[ZI_W-1:COORD_W];
        s2_pt_reg.seed_valid     <= 1'b1;
        s2_pt_reg.last           <= 1'b0;

        sqx_reg    <= prod_x[SQ_W-1:0];
        sqy_reg    <= prod_y[SQ_W-1:0];
        s3_zok_reg <= s2_zok_reg;
        s3_pt_reg  <= s2_pt_reg;

        s4_pt_reg  <= s3_pt_reg;
    end

    assign out_tag   = s4_tag_reg;
    assign out_point = s4_pt_reg;

endmodule

`default_nettype wire

>>> hdl/ground_seed_point_search_unit.sv
// Top level of the ground seed point search unit: control, configuration and result queue.
`default_nettype none

// Channel   Dir  Handshake              Payload
// req       in   req_valid/req_ready    req_data   (opcode, coord_x/y/z, intensity)
// rsp       out  rsp_valid/rsp_ready    rsp_data   (seed_x/y/z, seed_intensity, seed_valid, last)
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// Clear, load and ignored opcodes leave the unit idle. A query reads the store one point
// per cycle into the compare pipeline until the last point or enough seeds, then pushes
// its final result in a finish state; an empty store goes straight to the finish state.
// Reset clears the point count and queue and sets the config to its defaults; store contents are not reset.
// Results sit in a queue of 2*MAX_SEEDS entries; any new transaction waits while
// it holds more than MAX_SEEDS results, so a query always has room for its seeds.

module ground_seed_point_search_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire gsps_pkg::req_item_t            req_data,

    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output gsps_pkg::rsp_item_t                 rsp_data,

    input  wire logic                           cfg_we,
    input  wire logic [gsps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gsps_pkg::CFG_W-1:0]     cfg_data
);
    import gsps_pkg::*;

    // configuration
    logic [R_W-1:0]            search_radius_reg;
    logic signed [COORD_W-1:0] height_offset_reg;
    logic [R_W-1:0]            height_margin_reg;
    logic [SEED_CFG_W-1:0]     max_seeds_reg;

    // control
    state_t                    state_reg, state_next;
    logic [PT_CNT_W-1:0]       point_count_reg;
    query_t                    query_reg;
    logic [SEED_W-1:0]         limit_reg, limit_next;
    logic [SEED_W-1:0]         n_reg;
    logic [PT_CNT_W-1:0]       addr_reg;
    logic                      issued_all_reg;
    scan_tag_t                 rd_tag_reg;
    logic                      pend_valid_reg;
    rsp_item_t                 pend_reg;

    // result queue
    rsp_item_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]        fifo_cnt_reg;

    logic                      accept, is_query, is_load, pop;
    logic                      store_wr;
    logic [XY_W-1:0]           rd_xy;
    logic [ZI_W-1:0]           rd_zi;
    match_tag_t                m_tag;
    rsp_item_t                 m_point;
    logic                      seed_hit, limit_hit, scan_end, last_addr;
    logic                      issue_en, push;
    rsp_item_t                 push_item, null_item;
    query_t                    query_next;
    logic signed [Z_W-1:0]     centre;

    assign req_ready = (state_reg == ST_IDLE) && (fifo_cnt_reg <= FIFO_CW'(MAX_SEEDS));
    assign accept    = req_valid && req_ready;
    assign is_query  = accept && (req_data.opcode == OP_QUERY);
    assign is_load   = accept && (req_data.opcode == OP_LOAD);
    assign store_wr  = is_load && (point_count_reg < PT_CNT_W'(MAX_POINTS));

    assign rsp_valid = (fifo_cnt_reg != '0);
    assign rsp_data  = fifo_mem[rd_ptr_reg];
    assign pop       = rsp_valid && rsp_ready;

    // pose window and squared radius, latched with the query
    always_comb
    begin
        centre = {{(Z_W-COORD_W){req_data.coord_z[COORD_W-1]}}, req_data.coord_z}
               - {{(Z_W-COORD_W){height_offset_reg[COORD_W-1]}}, height_offset_reg};
        query_next.px  = req_data.coord_x;
        query_next.py  = req_data.coord_y;
        query_next.zlo = centre - {{(Z_W-R_W){1'b0}}, height_margin_reg};
        query_next.zhi = centre + {{(Z_W-R_W){1'b0}}, height_margin_reg};
        query_next.r2  = R2_W'(search_radius_reg) * R2_W'(search_radius_reg);

        // zero counts as one, large values saturate
        if (max_seeds_reg == '0)
            limit_next = SEED_W'(1);
        else if (32'(max_seeds_reg) > MAX_SEEDS)
            limit_next = SEED_W'(MAX_SEEDS);
        else
            limit_next = SEED_W'(max_seeds_reg);
    end

    gsps_point_store u_store
    (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (point_count_reg[PT_IDX_W-1:0]),
        .wr_xy   ({req_data.coord_y, req_data.coord_x}),
        .wr_zi   ({req_data.intensity, req_data.coord_z}),
        .rd_en   (issue_en),
        .rd_addr (addr_reg[PT_IDX_W-1:0]),
        .rd_xy   (rd_xy),
        .rd_zi   (rd_zi)
    );

    gsps_match_pipe u_match
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (scan_end),
        .query     (query_reg),
        .in_tag    (rd_tag_reg),
        .in_xy     (rd_xy),
        .in_zi     (rd_zi),
        .out_tag   (m_tag),
        .out_point (m_point)
    );

    assign last_addr = (addr_reg == PT_CNT_W'(point_count_reg - 1'b1));
    assign seed_hit  = (state_reg == ST_SCAN) && m_tag.valid && m_tag.hit;
    assign limit_hit = seed_hit && (SEED_W'(n_reg + 1'b1) == limit_reg);
    // scan stops at the last stored point or once enough seeds are found
    assign scan_end  = (state_reg == ST_SCAN) && m_tag.valid && (m_tag.last || limit_hit);

    always_comb
    begin
        null_item      = '0;
        null_item.last = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                    state_next = (point_count_reg == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        issue_en  = 1'b0;
        push      = 1'b0;
        push_item = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                issue_en = 1'b0;
            end
            ST_SCAN:
            begin
                issue_en = !issued_all_reg && !scan_end;
                // previous seed is known not to be the final one
                push     = seed_hit && pend_valid_reg;
            end
            ST_FINISH:
            begin
                push = 1'b1;
                if (pend_valid_reg)
                begin
                    push_item      = pend_reg;
                    push_item.last = 1'b1;
                end
                else
                begin
                    push_item = null_item;
                end
            end
            default:
            begin
                issue_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_radius_reg <= R_W'(1000);
            height_offset_reg <= '0;
            height_margin_reg <= R_W'(500);
            max_seeds_reg     <= SEED_CFG_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEARCH_RADIUS: search_radius_reg <= cfg_data[R_W-1:0];
                CFG_HEIGHT_OFFSET: height_offset_reg <= cfg_data[COORD_W-1:0];
                CFG_HEIGHT_MARGIN: height_margin_reg <= cfg_data[R_W-1:0];
                CFG_MAX_SEEDS:     max_seeds_reg     <= cfg_data[SEED_CFG_W-1:0];
                default:           max_seeds_reg     <= max_seeds_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= '0;
            n_reg           <= '0;
            addr_reg        <= '0;
            issued_all_reg  <= 1'b0;
            rd_tag_reg      <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept && (req_data.opcode == OP_CLEAR))
                point_count_reg <= '0;
            else if (store_wr)
                point_count_reg <= PT_CNT_W'(point_count_reg + 1'b1);

            rd_tag_reg.valid <= issue_en;
            rd_tag_reg.last  <= last_addr;

            if (is_query)
            begin
                n_reg          <= '0;
                addr_reg       <= '0;
                issued_all_reg <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (issue_en)
                begin
                    addr_reg <= PT_CNT_W'(addr_reg + 1'b1);
                    if (last_addr)
                        issued_all_reg <= 1'b1;
                end
                if (seed_hit)
                begin
                    n_reg          <= SEED_W'(n_reg + 1'b1);
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            query_reg <= query_next;
            limit_reg <= limit_next;
        end
        if (seed_hit)
            pend_reg <= m_point;
    end

    // result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + 1'b1);
            priority if (push && !pop)
                fifo_cnt_reg <= FIFO_CW'(fifo_cnt_reg + 1'b1);
            else if (pop && !push)
                fifo_cnt_reg <= FIFO_CW'(fifo_cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire
